/* design/bounded_deque_with_search_macros.svh */
// assertion macros for the bounded deque with search
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define BDS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BDS_ASSERT(label, clk, rst, prop, msg)

`define BDS_ASSERT_SAME(label, clk, rst, ante, cons, msg)

`define BDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* design/bds_pkg.sv */
// shared types and constants for the bounded deque with search
package bds_pkg;

   localparam int ValueW      = 32;
   localparam int KindW       = 3;
   localparam int StatusW     = 2;
   localparam int CountW      = 5;
   localparam int DefCapacity = 16;

   typedef enum logic [KindW-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_REMOVE     = 3'd4,
      KIND_SEARCH     = 3'd5
   } kind_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD    = 3'd0,
      OP_SHIFT_R = 3'd1,
      OP_SHIFT_L = 3'd2,
      OP_ROTATE  = 3'd3,
      OP_WRITE   = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [ValueW-1:0] data;
   } cell_cmd_type;

endpackage

/* design/bds_cell.sv */
// one storage cell of the deque row
module bds_cell #(
   parameter int CAPACITY = bds_pkg::DefCapacity,
   parameter int INDEX    = 0
) (
   input  logic                             clock,
   input  bds_pkg::cell_cmd_type            cmd,
   input  logic [$clog2(CAPACITY)-1:0]      pos,
   input  logic signed [bds_pkg::ValueW-1:0] left_q,
   input  logic signed [bds_pkg::ValueW-1:0] right_q,
   input  logic signed [bds_pkg::ValueW-1:0] head_q,
   output logic signed [bds_pkg::ValueW-1:0] q
);

   localparam int IW = $clog2(CAPACITY);

   logic signed [bds_pkg::ValueW-1:0] entry_ff;
   logic signed [bds_pkg::ValueW-1:0] entry_in;
   logic                              is_pos;

   assign is_pos = (pos == IW'(INDEX));

   always_comb begin
      unique case (cmd.op)
         bds_pkg::OP_HOLD:    entry_in = entry_ff;
         bds_pkg::OP_SHIFT_R: entry_in = left_q;
         bds_pkg::OP_SHIFT_L: entry_in = right_q;
         bds_pkg::OP_ROTATE:  entry_in = is_pos ? head_q : right_q;
         bds_pkg::OP_WRITE:   entry_in = is_pos ? cmd.data : entry_ff;
         default:             entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

/* design/bds_row.sv */
// chain of cells holding the deque in head-to-tail order
module bds_row #(
   parameter int CAPACITY = bds_pkg::DefCapacity
) (
   input  logic                             clock,
   input  bds_pkg::cell_cmd_type            cmd,
   input  logic [$clog2(CAPACITY)-1:0]      pos,
   output logic signed [bds_pkg::ValueW-1:0] head_q
);

   logic signed [bds_pkg::ValueW-1:0] q [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [bds_pkg::ValueW-1:0] left_q;
      logic signed [bds_pkg::ValueW-1:0] right_q;

      if (i == 0) begin : g_first
         assign left_q = cmd.data;
      end else begin : g_mid_l
         assign left_q = q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_q = q[i];
      end else begin : g_mid_r
         assign right_q = q[i+1];
      end

      bds_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock   (clock),
         .cmd     (cmd),
         .pos     (pos),
         .left_q  (left_q),
         .right_q (right_q),
         .head_q  (q[0]),
         .q       (q[i])
      );
   end

   assign head_q = q[0];

endmodule

/* design/bounded_deque_with_search.sv */
// top level of the bounded deque with search: controller, row of cells, result register
// Bounded deque of signed 32-bit values held in a row of CAPACITY cells, cell 0 being the
// front. Push front, push back and pop front finish in the accepting cycle and can be issued
// back to back while the output is not stalled. Pop back, search and remove by value rotate
// the held entries past the single comparator at the front cell, one position per cycle,
// and keep the block busy while they do, so no new request is taken before one is through.
// On an empty store they answer in the accepting cycle. Each finished result is loaded into
// the output register, directly if that register is free. A request is taken only while no
// operation is in flight. A finished result that meets a stalled output waits in a holding
// register, and requests stay stalled until it has moved on. Entries never written hold no
// defined value, but only held entries are ever read.
`include "bounded_deque_with_search_macros.svh"

module bounded_deque_with_search #(
   parameter int CAPACITY = bds_pkg::DefCapacity
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bds_pkg::KindW-1:0]         req_kind,
   input  logic signed [bds_pkg::ValueW-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bds_pkg::StatusW-1:0]       rsp_status,
   output logic signed [bds_pkg::ValueW-1:0] rsp_popped_value,
   output logic                              rsp_found,
   output logic [bds_pkg::CountW-1:0]        rsp_count
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ROT,
      S_DONE
   } state_type;

   state_type                          state_ff, state_in;
   bds_pkg::kind_type                  kind_ff, kind_in;
   logic signed [bds_pkg::ValueW-1:0]  key_ff, key_in;
   logic [CW-1:0]                      steps_ff, steps_in;
   logic                               found_ff, found_in;
   logic [CW-1:0]                      count_ff, count_in;
   bds_pkg::status_type                res_status_ff, res_status_in;
   logic signed [bds_pkg::ValueW-1:0]  res_popped_ff, res_popped_in;
   logic                               res_found_ff, res_found_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   bds_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic signed [bds_pkg::ValueW-1:0]  rsp_popped_ff, rsp_popped_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [bds_pkg::CountW-1:0]         rsp_count_ff, rsp_count_in;

   bds_pkg::kind_type                  req_kind_t;
   bds_pkg::cell_cmd_type              cmd;
   logic [IW-1:0]                      pos;
   logic signed [bds_pkg::ValueW-1:0]  head_q;
   logic [CW-1:0]                      count_m1;
   logic [IW-1:0]                      last_idx;
   logic                               out_free;
   logic                               finish;
   logic                               load;
   logic                               hit;
   logic                               push_full;

   bds_row #(
      .CAPACITY (CAPACITY)
   ) u_row (
      .clock  (clock),
      .cmd    (cmd),
      .pos    (pos),
      .head_q (head_q)
   );

   assign req_kind_t = bds_pkg::kind_type'(req_kind);
   assign req_stall  = (state_ff != S_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign count_m1   = count_ff - CW'(1);
   assign last_idx   = count_m1[IW-1:0];
   assign push_full  = (state_ff == S_IDLE) && req_valid && (count_ff == CW'(CAPACITY))
                       && ((req_kind_t == bds_pkg::KIND_PUSH_FRONT)
                           || (req_kind_t == bds_pkg::KIND_PUSH_BACK));

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      steps_in      = steps_ff;
      found_in      = found_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_popped_in = res_popped_ff;
      res_found_in  = res_found_ff;
      cmd.op        = bds_pkg::OP_HOLD;
      cmd.data      = req_value;
      pos           = '0;
      finish        = 1'b0;
      hit           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in       = req_kind_t;
               key_in        = req_value;
               found_in      = 1'b0;
               res_status_in = bds_pkg::ST_OK;
               res_popped_in = '0;
               res_found_in  = 1'b0;
               unique case (req_kind_t)
                  bds_pkg::KIND_PUSH_FRONT, bds_pkg::KIND_PUSH_BACK: begin
                     finish = 1'b1;
                     if (count_ff == CW'(CAPACITY)) begin
                        res_status_in = bds_pkg::ST_FULL;
                     end else begin
                        cmd.op   = (req_kind_t == bds_pkg::KIND_PUSH_FRONT) ?
                                   bds_pkg::OP_SHIFT_R : bds_pkg::OP_WRITE;
                        pos      = count_ff[IW-1:0];
                        count_in = count_ff + CW'(1);
                     end
                  end
                  bds_pkg::KIND_POP_FRONT: begin
                     finish = 1'b1;
                     if (count_ff == '0) begin
                        res_status_in = bds_pkg::ST_EMPTY;
                     end else begin
                        res_popped_in = head_q;
                        cmd.op        = bds_pkg::OP_SHIFT_L;
                        count_in      = count_m1;
                     end
                  end
                  bds_pkg::KIND_POP_BACK: begin
                     if (count_ff == '0) begin
                        finish        = 1'b1;
                        res_status_in = bds_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_ROT;
                        steps_in = count_m1;
                     end
                  end
                  bds_pkg::KIND_REMOVE, bds_pkg::KIND_SEARCH: begin
                     if (count_ff == '0) begin
                        finish        = 1'b1;
                        res_status_in = bds_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_ROT;
                        steps_in = count_ff;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_ROT: begin
            if (kind_ff == bds_pkg::KIND_POP_BACK) begin
               if (steps_ff == '0) begin
                  res_popped_in = head_q;
                  cmd.op        = bds_pkg::OP_SHIFT_L;
                  count_in      = count_m1;
                  finish        = 1'b1;
               end else begin
                  cmd.op   = bds_pkg::OP_ROTATE;
                  pos      = last_idx;
                  steps_in = steps_ff - CW'(1);
               end
            end else begin
               hit = !found_ff && (head_q == key_ff);
               if (hit && (kind_ff == bds_pkg::KIND_REMOVE)) begin
                  cmd.op   = bds_pkg::OP_SHIFT_L;
                  count_in = count_m1;
               end else begin
                  cmd.op = bds_pkg::OP_ROTATE;
                  pos    = last_idx;
               end
               found_in = found_ff || hit;
               steps_in = steps_ff - CW'(1);
               if (steps_ff == CW'(1)) begin
                  finish        = 1'b1;
                  res_found_in  = found_in;
                  res_status_in = found_in ? bds_pkg::ST_OK : bds_pkg::ST_NOT_FOUND;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // result goes out now if the output register is free, else it is held
      if (finish) begin
         state_in = out_free ? S_IDLE : S_DONE;
      end
   end

   assign load = (finish || (state_ff == S_DONE)) && out_free;

   always_comb begin
      rsp_valid_in  = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_status_in = load ? res_status_in : rsp_status_ff;
      rsp_popped_in = load ? res_popped_in : rsp_popped_ff;
      rsp_found_in  = load ? res_found_in : rsp_found_ff;
      rsp_count_in  = load ? bds_pkg::CountW'(count_in) : rsp_count_ff;
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      steps_ff      <= steps_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_popped_ff <= res_popped_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_count        = rsp_count_ff;

   `BDS_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "fill count above capacity")
   `BDS_ASSERT_SAME(a_rot_steps, clock, reset, state_ff == S_ROT, (steps_ff <= count_ff) && (count_ff != '0), "rotation out of range")
   `BDS_ASSERT_SAME(a_done_blocked, clock, reset, state_ff == S_DONE, rsp_valid_ff, "result held with free output")
   `BDS_ASSERT_NEXT(a_full_push, clock, reset, push_full, $stable(count_ff), "rejected push changed count")

endmodule
